// ===== sv/lsmf_pkg.sv =====
`default_nettype none

package lsmf_pkg;

  localparam int unsigned QUERY_SLOTS = 16;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned LEN_W       = 5;
  localparam int unsigned IDX_W       = 16;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CFG_IDX_W   = 2;

  typedef logic [QUERY_SLOTS-1:0][BYTE_W-1:0] query_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUERY_LOW  = 2'd0,
    CFG_QUERY_HIGH = 2'd1,
    CFG_QUERY_LEN  = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_idx_e;

endpackage

`default_nettype wire

// ===== sv/lsmf_cell.sv =====
`default_nettype none

module lsmf_cell #(
  parameter int unsigned IDX = 0
) (
  input  wire logic                         clk_i,
  input  wire logic                         shift_i,
  input  wire logic [lsmf_pkg::BYTE_W-1:0]  byte_i,
  input  wire lsmf_pkg::query_t             query_i,
  input  wire logic [lsmf_pkg::LEN_W-1:0]   len_i,
  output logic      [lsmf_pkg::BYTE_W-1:0]  byte_o,
  output logic                              hit_o
);
  import lsmf_pkg::*;

  logic [BYTE_W-1:0] byte_q;
  logic [LEN_W-1:0]  qpos;

  // window slot IDX lines up with query byte len-1-IDX
  assign qpos   = len_i - LEN_W'(1) - LEN_W'(IDX);
  assign hit_o  = (LEN_W'(IDX) >= len_i) || (byte_i == query_i[qpos[3:0]]);
  assign byte_o = byte_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/last_substring_match_finder.sv =====
// Channel  | Handshake                   | Payload
// text in | in_valid_i / in_stall_o     | text_byte_i, end_of_text_i
// result   | out_valid_o / out_stall_i   | found_o, match_index_o, text_too_long_o
// config   | cfg_valid_i / cfg_ready_o   | cfg_index_i, cfg_data_i
//
// One text byte per cycle; each byte is compared against the query combinationally
// across the row of window cells. End-of-text loads the result register at the
// accepting edge; the result is offered from the next cycle. Text bytes
// are taken even while a result is held; an end-of-text request stalls only
// while the held result is stalled.
// Reset clears the query, counters, flags and the result valid.
`default_nettype none

module last_substring_match_finder #(
  parameter int unsigned MAX_QUERY_BYTES = 16,
  parameter longint      MAX_TEXT_BYTES  = 65536
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [7:0]                        text_byte_i,
  input  wire logic                              end_of_text_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic                                   found_o,
  output logic [15:0]                            match_index_o,
  output logic                                   text_too_long_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [lsmf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [lsmf_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import lsmf_pkg::*;

  localparam int unsigned CW = $clog2(MAX_TEXT_BYTES + 1);
  localparam int unsigned AW = (CW > IDX_W) ? CW : IDX_W;

  logic [CFG_DATA_W-1:0] qlow_q, qhigh_q;
  logic [LEN_W-1:0]      qlen_q;
  query_t                query;

  logic [CW-1:0]    cnt_q, cnt_d, cnt_inc;
  logic [IDX_W-1:0] start_q, start_d;
  logic             seen_q, seen_d;
  logic             ovf_q, ovf_d;
  logic             out_vld_q, out_vld_d;
  logic             found_q;
  logic [IDX_W-1:0] idx_q;
  logic             tl_q;

  logic             acc, acc_eot, sat, shift;
  logic             len_ok, long_enough, match;
  logic [AW-1:0]    start_w;

  logic [MAX_QUERY_BYTES-1:0][BYTE_W-1:0] cell_byte;
  logic [MAX_QUERY_BYTES-1:0]             cell_hit;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qlow_q  <= '0;
      qhigh_q <= '0;
      qlen_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_QUERY_LOW:  qlow_q  <= cfg_data_i;
        CFG_QUERY_HIGH: qhigh_q <= cfg_data_i;
        CFG_QUERY_LEN:  qlen_q  <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign query = {qhigh_q, qlow_q};

  assign in_stall_o = out_vld_q && out_stall_i && end_of_text_i;
  assign acc        = in_valid_i && !in_stall_o;
  assign acc_eot    = acc && end_of_text_i;
  assign sat        = (cnt_q == CW'(MAX_TEXT_BYTES));
  assign shift      = acc && !end_of_text_i && !sat;

  for (genvar j = 0; j < MAX_QUERY_BYTES; j++) begin : g_cell
    lsmf_cell #(.IDX(j)) u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .byte_i  ((j == 0) ? text_byte_i : cell_byte[(j == 0) ? 0 : j-1]),
      .query_i (query),
      .len_i   (qlen_q),
      .byte_o  (cell_byte[j]),
      .hit_o   (cell_hit[j])
    );
  end

  assign cnt_inc     = cnt_q + CW'(1);
  assign len_ok      = (qlen_q != '0) && (32'(qlen_q) <= MAX_QUERY_BYTES);
  assign long_enough = AW'(cnt_inc) >= AW'(qlen_q);
  assign match       = len_ok && long_enough && (&cell_hit);
  assign start_w     = AW'(cnt_inc) - AW'(qlen_q);

  always_comb begin
    cnt_d   = cnt_q;
    start_d = start_q;
    seen_d  = seen_q;
    ovf_d   = ovf_q;
    if (acc_eot) begin
      cnt_d   = '0;
      start_d = '0;
      seen_d  = 1'b0;
      ovf_d   = 1'b0;
    end else if (acc && sat) begin
      ovf_d = 1'b1;
    end else if (shift) begin
      cnt_d = cnt_inc;
      if (match) begin
        start_d = start_w[IDX_W-1:0];
        seen_d  = 1'b1;
      end
    end
  end

  assign out_vld_d = acc_eot || (out_vld_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      start_q   <= '0;
      seen_q    <= 1'b0;
      ovf_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      start_q   <= start_d;
      seen_q    <= seen_d;
      ovf_q     <= ovf_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_eot) begin
      found_q <= seen_q;
      idx_q   <= seen_q ? start_q : '0;
      tl_q    <= ovf_q;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign found_o         = found_q;
  assign match_index_o   = idx_q;
  assign text_too_long_o = tl_q;

endmodule

`default_nettype wire

// ===== sv/lsmf_checker.sv =====
`default_nettype none

module lsmf_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        end_of_text_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic        found_o,
  input wire logic [15:0] match_index_o,
  input wire logic        text_too_long_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(found_o)
      && $stable(match_index_o) && $stable(text_too_long_o))
    else $error("result changed while stalled");

  a_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> match_index_o == 16'd0)
    else $error("index nonzero on not found");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without held result");

  a_eot_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && end_of_text_i |=> out_valid_o)
    else $error("end of text gave no result");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !(in_valid_i && !in_stall_o && end_of_text_i)
      |=> !out_valid_o)
    else $error("result repeated");

endmodule

bind last_substring_match_finder lsmf_checker u_lsmf_checker (.*);

`default_nettype wire

// ===== test/tb_top.sv =====
module tb_top;
  import lsmf_pkg::*;

  localparam longint TEXT_LIMIT = 65536;

  typedef struct packed {
    logic        found;
    logic [15:0] match_index;
    logic        text_too_long;
  } search_result_t;

  typedef logic [7:0] text_q_t[$];

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  in_valid_i    = 1'b0;
  logic [7:0]            text_byte_i   = 8'h00;
  logic                  end_of_text_i = 1'b0;
  logic                  out_stall_i   = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = CFG_QUERY_LOW;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  in_stall_o;
  logic                  out_valid_o;
  logic                  found_o;
  logic [15:0]           match_index_o;
  logic                  text_too_long_o;
  logic                  cfg_ready_o;

  last_substring_match_finder #(
    .MAX_QUERY_BYTES(16),
    .MAX_TEXT_BYTES (TEXT_LIMIT)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .text_byte_i    (text_byte_i),
    .end_of_text_i  (end_of_text_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .found_o        (found_o),
    .match_index_o  (match_index_o),
    .text_too_long_o(text_too_long_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // search model state
  logic [63:0]       q_lo = '0;
  logic [63:0]       q_hi = '0;
  logic [4:0]        q_len = '0;
  logic [15:0][7:0]  win_bytes = '0;
  int unsigned       byte_count = 0;
  int unsigned       latest_start = 0;
  bit                have_match = 1'b0;
  bit                count_saturated = 1'b0;

  search_result_t    expected_results[$];
  int                mismatch_count = 0;
  int                items_sent = 0;
  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  logic [7:0]        letters[4];

  function automatic void clear_text_state();
    win_bytes       = '0;
    byte_count      = 0;
    latest_start    = 0;
    have_match      = 1'b0;
    count_saturated = 1'b0;
  endfunction

  function automatic void apply_query_write(cfg_idx_e idx, logic [63:0] data);
    case (idx)
      CFG_QUERY_LOW:  q_lo = data;
      CFG_QUERY_HIGH: q_hi = data;
      CFG_QUERY_LEN:  q_len = data[4:0];
      default: ;
    endcase
  endfunction

  function automatic void predict_search(logic [7:0] b, logic eot);
    search_result_t r;
    query_t         q;
    bit             hit;
    q = {q_hi, q_lo};
    if (eot) begin
      r.found         = have_match;
      r.match_index   = have_match ? latest_start[15:0] : 16'd0;
      r.text_too_long = count_saturated;
      expected_results.push_back(r);
      clear_text_state();
    end else if (byte_count >= TEXT_LIMIT) begin
      count_saturated = 1'b1;
    end else begin
      win_bytes = {win_bytes[14:0], b};
      byte_count++;
      if (q_len >= 1 && q_len <= 16 && byte_count >= q_len) begin
        hit = 1'b1;
        for (int k = 0; k < q_len; k++)
          if (win_bytes[q_len - 1 - k] != q[k]) hit = 1'b0;
        if (hit) begin
          latest_start = byte_count - q_len;
          have_match   = 1'b1;
        end
      end
    end
  endfunction

  function automatic void check_result();
    search_result_t got, want;
    got.found         = found_o;
    got.match_index   = match_index_o;
    got.text_too_long = text_too_long_o;
    if (expected_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("unexpected result: found=%0b index=%0d too_long=%0b",
                 got.found, got.match_index, got.text_too_long);
    end else begin
      want = expected_results.pop_front();
      if (got.found !== want.found || got.match_index !== want.match_index ||
          got.text_too_long !== want.text_too_long) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("result mismatch: expected found=%0b index=%0d too_long=%0b, %s%0b %s%0d %s%0b",
                   want.found, want.match_index, want.text_too_long,
                   "got found=", got.found, "index=", got.match_index,
                   "too_long=", got.text_too_long);
      end
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_result();
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic send_item(logic [7:0] b, logic eot);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    text_byte_i   <= b;
    end_of_text_i <= eot;
    do @(posedge clk_i); while (in_stall_o);
    predict_search(b, eot);
    items_sent++;
  endtask

  task automatic send_text(text_q_t text);
    foreach (text[i]) send_item(text[i], 1'b0);
    send_item(8'($urandom_range(255)), 1'b1);
  endtask

  // bytes need no result, so allow the pipe to drain past the last one
  task automatic wait_block_idle();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [63:0] data);
    wait_block_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_query_write(idx, data);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_query(logic [127:0] qbytes, logic [4:0] len);
    logic [63:0] len_word;
    len_word      = {$urandom(), $urandom()};
    len_word[4:0] = len;
    write_reg(CFG_QUERY_LOW, qbytes[63:0]);
    write_reg(CFG_QUERY_HIGH, qbytes[127:64]);
    write_reg(CFG_QUERY_LEN, len_word);
  endtask

  task automatic randomize_query();
    logic [127:0] qbytes;
    logic [4:0]   len;
    int           pick;
    for (int i = 0; i < 4; i++) letters[i] = 8'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 4) len = 5'd0;
    else if (pick < 9) len = 5'($urandom_range(31, 17));
    else if (pick < 24) len = 5'd16;
    else if (pick < 34) len = 5'($urandom_range(15, 7));
    else len = 5'($urandom_range(6, 1));
    for (int k = 0; k < 16; k++)
      qbytes[k*8 +: 8] = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                  : letters[$urandom_range(3)];
    set_query(qbytes, len);
  endtask

  task automatic test_empty_query();
    send_item(8'hFF, 1'b1);
    send_text('{8'h00});
  endtask

  task automatic test_overlong_length();
    write_reg(CFG_UNUSED, '1);
    set_query(128'h0, 5'd31);
    send_text('{8'h00});
    set_query(128'h0, 5'd17);
    send_text('{8'h00});
  endtask

  task automatic test_zero_byte_query();
    set_query(128'h00, 5'd1);
    send_text('{8'h00, 8'hFF, 8'h00});
    // text shorter than the query
    set_query(128'hFF00FF, 5'd3);
    send_text('{8'hFF, 8'h00});
  endtask

  task automatic test_mid_text_config();
    set_query(128'hCDAB, 5'd2);
    send_item(8'hAB, 1'b0);
    send_item(8'hCD, 1'b0);
    set_query(128'hAB, 5'd1);
    send_item(8'hAB, 1'b0);
    send_item(8'h00, 1'b1);
    set_query(128'hCDAB, 5'd2);
    send_item(8'hAB, 1'b0);
    send_item(8'hCD, 1'b0);
    set_query(128'h2211, 5'd2);
    send_item(8'h33, 1'b0);
    send_item(8'h00, 1'b1);
  endtask

  task automatic test_random_texts(int item_budget);
    text_q_t text;
    query_t  q;
    int      start, target, pick, cut;
    bit      split;
    start = items_sent;
    randomize_query();
    while (items_sent - start < item_budget) begin
      if ($urandom_range(2) == 0) randomize_query();
      q = {q_hi, q_lo};
      text.delete();
      target = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(24);
      while (text.size() < target) begin
        pick = $urandom_range(99);
        if (pick < 35) begin
          for (int k = 0; k < q_len && k < 16; k++) text.push_back(q[k]);
        end else if (pick < 55) begin
          cut = $urandom_range(15);
          for (int k = 0; k < cut; k++) text.push_back(q[k]);
        end else begin
          text.push_back(($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                  : letters[$urandom_range(3)]);
        end
      end
      split = ($urandom_range(9) == 0);
      foreach (text[i]) begin
        if (split && i == text.size() / 2) randomize_query();
        send_item(text[i], 1'b0);
      end
      send_item(8'($urandom_range(255)), 1'b1);
    end
  endtask

  initial begin
    send_idle_pct = 38;
    recv_idle_pct = 68;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_query();
    test_overlong_length();
    test_zero_byte_query();
    test_mid_text_config();
    test_random_texts(280);
    send_idle_pct = 68;
    recv_idle_pct = 38;
    test_random_texts(280);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_texts(270);
    wait_block_idle();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #16000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/lsmf_pkg.sv
sv/lsmf_cell.sv
sv/last_substring_match_finder.sv
sv/lsmf_checker.sv
test/tb_top.sv
